[src/lkvc_pkg.sv]
// lkvc_pkg: shared types and constants for the LRU key-value cache.
// No dependencies; used by lkvc_cell and lru_key_value_cache.
package lkvc_pkg;

	// width and reset value of the capacity register
	localparam int unsigned CAP_BITS  = 5;
	localparam int unsigned CAP_RESET = 16;

	// flags rippled from cell to cell: has a lower-numbered cell already claimed the role
	typedef struct packed {
		logic hit_seen;
		logic free_seen;
		logic lru_seen;
	} chain_t;

	// action broadcast to every cell for the item being accepted
	typedef struct packed {
		logic apply;
		logic is_put;
		logic do_hit;
		logic do_fill;
		logic do_replace;
	} cmd_t;

endpackage

[src/lkvc_cell.sv]
// lkvc_cell: one cache slot (key, value, valid, recency rank) with its compare logic.
// Depends on lkvc_pkg (chain_t, cmd_t).
module lkvc_cell #(
	parameter int unsigned KEY_BITS   = 16,
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned RANK_W     = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [KEY_BITS-1:0]   key_in,
	input  logic [VALUE_BITS-1:0] value_in,
	input  lkvc_pkg::cmd_t        cmd,
	input  logic [RANK_W-1:0]     promote_rank,
	input  logic [RANK_W-1:0]     top_rank,
	input  logic [RANK_W-1:0]     fill_rank,
	input  lkvc_pkg::chain_t      chain_in,
	output lkvc_pkg::chain_t      chain_out,
	input  logic [VALUE_BITS-1:0] hit_value_in,
	output logic [VALUE_BITS-1:0] hit_value_out,
	input  logic [RANK_W-1:0]     hit_rank_in,
	output logic [RANK_W-1:0]     hit_rank_out,
	input  logic [KEY_BITS-1:0]   lru_key_in,
	output logic [KEY_BITS-1:0]   lru_key_out
);

	logic                  valid_q;
	logic [RANK_W-1:0]     rank_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	logic first_hit;
	logic first_free;
	logic first_lru;
	logic do_promote;
	logic mine_promote;
	logic write_key;
	logic write_value;

	always_comb begin
		first_hit  = valid_q && (key_q == key_in) && !chain_in.hit_seen;
		first_lru  = valid_q && (rank_q == '0) && !chain_in.lru_seen;
		first_free = !valid_q && !chain_in.free_seen;

		chain_out.hit_seen  = chain_in.hit_seen || first_hit;
		chain_out.lru_seen  = chain_in.lru_seen || first_lru;
		chain_out.free_seen = chain_in.free_seen || first_free;

		hit_value_out = hit_value_in | (first_hit ? value_q : '0);
		hit_rank_out  = hit_rank_in | (first_hit ? rank_q : '0);
		lru_key_out   = lru_key_in | (first_lru ? key_q : '0);

		do_promote   = cmd.do_hit || cmd.do_replace;
		mine_promote = cmd.do_hit ? first_hit : first_lru;
		write_key    = (cmd.do_replace && first_lru) || (cmd.do_fill && first_free);
		write_value  = write_key || (cmd.do_hit && first_hit && cmd.is_put);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.apply) begin
			if (do_promote) begin
				if (mine_promote) begin
					rank_q <= top_rank;
				end else if (valid_q && (rank_q > promote_rank)) begin
					rank_q <= rank_q - 1'b1;
				end
			end
			if (cmd.do_fill && first_free) begin
				valid_q <= 1'b1;
				rank_q  <= fill_rank;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && write_key) begin
			key_q <= key_in;
		end
		if (cmd.apply && write_value) begin
			value_q <= value_in;
		end
	end

endmodule

[src/lru_key_value_cache.sv]
// lru_key_value_cache: fully associative key-value cache with LRU replacement.
// Depends on lkvc_pkg and lkvc_cell.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------------
//  in      | s_tvalid s_tready      | s_tuser: op; s_tdata: key, value
//  out     | m_tvalid m_tready      | m_tuser: found, evicted; m_tdata: read_value, evicted_key
//  cfg     | cfg_valid cfg_ready    | cfg_data: capacity, always ready
//
// One item per cycle while s_tready is high: every cell compares the key in the accept cycle and the
// lowest-numbered hit/free/LRU slot is picked by a flag ripple through the row of cells.
// The result is written into the output register as the item is accepted.
// s_tready drops only while a result sits in the output register and m_tready is low.
// Reset clears all valid bits, ranks and the entry count at once; no clearing pass.
module lru_key_value_cache #(
	parameter int unsigned ENTRIES    = 16,
	parameter int unsigned KEY_BITS   = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // key, value, zero pad
	input  logic [0:0]              s_tuser,   // op
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [((VALUE_BITS + KEY_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	                                           // read_value, evicted_key, zero pad
	output logic [1:0]              m_tuser,   // found, evicted
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [lkvc_pkg::CAP_BITS-1:0] cfg_data  // capacity
);

	localparam int unsigned OUT_W  = ((VALUE_BITS + KEY_BITS + 7) / 8) * 8;
	localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
	localparam int unsigned CW     = ((CNT_W > lkvc_pkg::CAP_BITS) ? CNT_W
	                                  : lkvc_pkg::CAP_BITS) + 1;

	logic [lkvc_pkg::CAP_BITS-1:0] capacity_q;
	logic [CNT_W-1:0]              used_q;
	logic                          m_tvalid_q;
	logic [OUT_W-1:0]              m_tdata_q;
	logic [1:0]                    m_tuser_q;

	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;
	logic                  is_put;
	logic                  accept;

	lkvc_pkg::chain_t      chain [ENTRIES+1];
	logic [VALUE_BITS-1:0] hit_value [ENTRIES+1];
	logic [RANK_W-1:0]     hit_rank [ENTRIES+1];
	logic [KEY_BITS-1:0]   lru_key [ENTRIES+1];

	lkvc_pkg::cmd_t    cmd;
	logic [RANK_W-1:0] promote_rank;
	logic [RANK_W-1:0] top_rank;
	logic [RANK_W-1:0] fill_rank;
	logic [CW-1:0]     cap_ext;
	logic [CW-1:0]     eff_cap;
	logic [CNT_W-1:0]  used_dec;
	logic              room;

	assign key       = s_tdata[KEY_BITS-1:0];
	assign value     = s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
	assign is_put    = s_tuser[0];
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	assign chain[0]     = '0;
	assign hit_value[0] = '0;
	assign hit_rank[0]  = '0;
	assign lru_key[0]   = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.KEY_BITS  (KEY_BITS),
			.VALUE_BITS(VALUE_BITS),
			.RANK_W    (RANK_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.key_in       (key),
			.value_in     (value),
			.cmd          (cmd),
			.promote_rank (promote_rank),
			.top_rank     (top_rank),
			.fill_rank    (fill_rank),
			.chain_in     (chain[i]),
			.chain_out    (chain[i+1]),
			.hit_value_in (hit_value[i]),
			.hit_value_out(hit_value[i+1]),
			.hit_rank_in  (hit_rank[i]),
			.hit_rank_out (hit_rank[i+1]),
			.lru_key_in   (lru_key[i]),
			.lru_key_out  (lru_key[i+1])
		);
	end

	always_comb begin
		// capacity clamped to 1..ENTRIES
		cap_ext = CW'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		room = (CW'(used_q) < eff_cap) && chain[ENTRIES].free_seen;

		cmd.apply      = accept;
		cmd.is_put     = is_put;
		cmd.do_hit     = chain[ENTRIES].hit_seen;
		cmd.do_fill    = !chain[ENTRIES].hit_seen && is_put && room;
		cmd.do_replace = !chain[ENTRIES].hit_seen && is_put && !room
		                 && chain[ENTRIES].lru_seen;

		used_dec     = used_q - 1'b1;
		top_rank     = used_dec[RANK_W-1:0];
		fill_rank    = used_q[RANK_W-1:0];
		promote_rank = chain[ENTRIES].hit_seen ? hit_rank[ENTRIES] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAP_BITS'(lkvc_pkg::CAP_RESET);
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			if (accept && cmd.do_fill) begin
				used_q <= used_q + 1'b1;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= OUT_W'({
				(cmd.do_replace ? lru_key[ENTRIES] : {KEY_BITS{1'b0}}),
				((cmd.do_hit && !is_put) ? hit_value[ENTRIES] : {VALUE_BITS{1'b0}})
			});
			m_tuser_q <= {cmd.do_replace, cmd.do_hit};
		end
	end

endmodule
